[src/ffr_pkg.sv]
// ---------------------------------------------------------------------------
// ffr_pkg
// Shared types, sizes and helpers for the ring FIFO with indexed read.
// ---------------------------------------------------------------------------
package ffr_pkg;

  // Storage sizes
  localparam int DEPTH     = 64;
  localparam int DATA_BITS = 32;
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Fixed field widths of the transaction payloads
  localparam int OP_W   = 3;
  localparam int WORD_W = 32;
  localparam int IDX_W  = 6;
  localparam int LEN_W  = 7;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 3'd0,
    OP_POP        = 3'd1,
    OP_TRAV_START = 3'd2,
    OP_TRAV_AT    = 3'd3,
    OP_RANGE      = 3'd4
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] push_data;
    logic [IDX_W-1:0]  index;
    logic [IDX_W-1:0]  end_index;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] data;
    logic              has_data;
    logic [IDX_W-1:0]  next_index;
    logic [LEN_W-1:0]  length;
    logic [IDX_W-1:0]  head_slot;
    logic [IDX_W-1:0]  tail_slot;
    logic              is_empty;
    logic              is_full;
    logic              last;
  } out_item_t;

  // Reduce a slot number modulo DEPTH by binary compare and subtract
  function automatic logic [PTR_W-1:0] mod_depth(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = v;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (int'(r) >= (DEPTH << k)) begin
        r = r - IDX_W'(DEPTH << k);
      end
    end
    return PTR_W'(r);
  endfunction

  // Advance a slot pointer with wraparound
  function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

[src/ffr_ram.sv]
// ---------------------------------------------------------------------------
// ffr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ffr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ffr_seq.sv]
// ---------------------------------------------------------------------------
// ffr_seq
// Operation sequencer: pointers, fill count, slot valid bits and the
// write and read access to the slot RAM; one operation at a time.
// ---------------------------------------------------------------------------
module ffr_seq import ffr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res_data
);

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DEPTH-1:0]  vld_r, vld_nxt;
  logic              vld_q_r, vld_q_nxt;

  // Per-transaction result fields
  logic              ok_r, ok_nxt;
  logic              has_r, has_nxt;
  logic              range_r, range_nxt;
  logic [IDX_W-1:0]  nidx_r, nidx_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [PTR_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;

  // RAM access
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [DATA_BITS-1:0] ram_wdata;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [DATA_BITS-1:0] ram_rdata;

  logic [PTR_W-1:0]  idx_m;
  logic [PTR_W-1:0]  end_m;
  logic [CNT_W-1:0]  win_off;
  logic [CNT_W-1:0]  span;
  logic              is_last;

  ffr_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode slot numbers, window offset and range length
  always_comb begin
    idx_m   = mod_depth(in_data.index);
    end_m   = mod_depth(in_data.end_index);
    win_off = (idx_m >= head_r) ? CNT_W'(idx_m) - CNT_W'(head_r)
                                : CNT_W'(idx_m) + CNT_W'(DEPTH) - CNT_W'(head_r);
    span    = (idx_m <= end_m) ? CNT_W'(end_m) - CNT_W'(idx_m) + 1'b1
                               : CNT_W'(end_m) + CNT_W'(DEPTH) + 1'b1 - CNT_W'(idx_m);
  end

  assign is_last  = !range_r || (rem_r == CNT_W'(1));
  assign in_stall = (state_r != S_IDLE);

  // Sequence operations
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    ok_nxt    = ok_r;
    has_nxt   = has_r;
    range_nxt = range_r;
    nidx_nxt  = nidx_r;
    len_nxt   = len_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    ram_we    = 1'b0;
    ram_waddr = inc_ptr(tail_r);
    ram_wdata = DATA_BITS'(in_data.push_data);
    ram_re    = 1'b0;
    ram_raddr = head_r;
    res_valid = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RESULT;
          ok_nxt    = 1'b0;
          has_nxt   = 1'b0;
          range_nxt = 1'b0;
          nidx_nxt  = '0;
          len_nxt   = LEN_W'(cnt_r);
          unique case (in_data.op)
            OP_PUSH: begin
              if (cnt_r != CNT_W'(DEPTH)) begin
                tail_nxt = inc_ptr(tail_r);
                ram_we   = 1'b1;
                cnt_nxt  = cnt_r + 1'b1;
                ok_nxt   = 1'b1;
                len_nxt  = LEN_W'(cnt_r + 1'b1);
              end
            end
            OP_POP: begin
              if (cnt_r != '0) begin
                ram_re    = 1'b1;
                ram_raddr = head_r;
                head_nxt  = inc_ptr(head_r);
                cnt_nxt   = cnt_r - 1'b1;
                ok_nxt    = 1'b1;
                has_nxt   = 1'b1;
                len_nxt   = LEN_W'(cnt_r - 1'b1);
              end
            end
            OP_TRAV_START: begin
              nidx_nxt = IDX_W'(head_r);
            end
            OP_TRAV_AT: begin
              if ((cnt_r != '0) && (win_off < cnt_r)) begin
                ram_re    = 1'b1;
                ram_raddr = idx_m;
                ok_nxt    = 1'b1;
                has_nxt   = 1'b1;
                nidx_nxt  = IDX_W'(inc_ptr(idx_m));
              end else begin
                nidx_nxt  = IDX_W'(inc_ptr(head_r));
              end
            end
            OP_RANGE: begin
              ram_re    = 1'b1;
              ram_raddr = idx_m;
              has_nxt   = 1'b1;
              range_nxt = 1'b1;
              cur_nxt   = idx_m;
              rem_nxt   = span;
              len_nxt   = LEN_W'(span);
            end
            default: begin
            end
          endcase
        end
      end
      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            // Fetch the next slot of the range while this one is taken
            cur_nxt   = inc_ptr(cur_r);
            rem_nxt   = rem_r - 1'b1;
            ram_re    = 1'b1;
            ram_raddr = inc_ptr(cur_r);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Track written slots and the valid bit of the slot being read
  always_comb begin
    vld_nxt   = vld_r;
    vld_q_nxt = vld_q_r;
    if (ram_we) begin
      vld_nxt[ram_waddr] = 1'b1;
    end
    if (ram_re) begin
      vld_q_nxt = vld_r[ram_raddr];
    end
  end

  // Hold state and registered result fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= PTR_W'(DEPTH - 1);
      cnt_r   <= '0;
      vld_r   <= '0;
      vld_q_r <= 1'b0;
      ok_r    <= 1'b0;
      has_r   <= 1'b0;
      range_r <= 1'b0;
      nidx_r  <= '0;
      len_r   <= '0;
      cur_r   <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
      vld_q_r <= vld_q_nxt;
      ok_r    <= ok_nxt;
      has_r   <= has_nxt;
      range_r <= range_nxt;
      nidx_r  <= nidx_nxt;
      len_r   <= len_nxt;
      cur_r   <= cur_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Assemble the result; unwritten slots read as zero
  always_comb begin
    res_data.ok         = ok_r;
    res_data.data       = (has_r && vld_q_r) ? WORD_W'(ram_rdata) : '0;
    res_data.has_data   = has_r;
    res_data.next_index = nidx_r;
    res_data.length     = len_r;
    res_data.head_slot  = IDX_W'(head_r);
    res_data.tail_slot  = IDX_W'(tail_r);
    res_data.is_empty   = (cnt_r == '0);
    res_data.is_full    = (cnt_r == CNT_W'(DEPTH));
    res_data.last       = is_last;
  end

endmodule

[src/ring_fifo_with_indexed_read_core.sv]
// ---------------------------------------------------------------------------
// ring_fifo_with_indexed_read_core
// Circular FIFO with push, pop, traverse and range read over one slot RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one operation per
//   transaction: push, pop, traverse start, traverse at index or range read.
//   Result channel out_valid / out_stall / out_data returns the results,
//   each with the fill count or range span, head and tail slots and empty/full flags.
//   Every operation gives one result, except range read, which gives one
//   result per slot from start to end slot with wraparound; the final
//   result of a transaction has last set.
//   A result passes through the RAM read and sequencer result registers,
//   then through the output register, before it appears on out_data.
//   The sequencer takes no new input transaction until the last result of
//   the current one is taken; a range read streams one slot per cycle while
//   out_stall is low.
//   in_stall stays high while a transaction is in progress.
//   Reset: slots read as zero until written (per-slot valid bits), head 0,
//   tail at the last slot, count 0; the block takes input right after reset.
//   While out_stall is high and out_valid is set, the output register holds
//   and the sequencer waits; no result is lost or repeated.
// ---------------------------------------------------------------------------
module ring_fifo_with_indexed_read_core import ffr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;
  logic      out_valid_r;
  out_item_t out_data_r;

  ffr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // Take a new result when the output register is free or being drained
  assign res_ready = !out_valid_r || !out_stall;

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  // Output register payload; hold while stalled
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[bench/ring_fifo_with_indexed_read_checker.sv]
// ---------------------------------------------------------------------------
// ring_fifo_with_indexed_read_checker
// Watches both channels of the ring FIFO, predicts every result from its own
// copy of the slots, head, tail and count, and compares each result field by
// field with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module ring_fifo_with_indexed_read_checker import ffr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_results,
  output int        results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 40;

  // Shadow of the FIFO contents and pointers
  logic [DATA_BITS-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]     head_slot_q;
  logic [PTR_W-1:0]     tail_slot_q;
  int unsigned          fill_q;
  out_item_t            expected_results [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
    results_checked = 0;
  end

  // Count a failure and print it while under the print cap
  task automatic report(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Build one result stamped with the status as it stands now
  function automatic out_item_t status_item(input logic ok, input logic [WORD_W-1:0] word,
                                            input logic has, input logic [IDX_W-1:0] nxt,
                                            input int unsigned len, input logic fin);
    out_item_t r;
    r.ok         = ok;
    r.data       = word;
    r.has_data   = has;
    r.next_index = nxt;
    r.length     = LEN_W'(len);
    r.head_slot  = IDX_W'(head_slot_q);
    r.tail_slot  = IDX_W'(tail_slot_q);
    r.is_empty   = (fill_q == 0);
    r.is_full    = (fill_q == DEPTH);
    r.last       = fin;
    return r;
  endfunction

  // Apply one transaction to the shadow and queue the results it causes
  task automatic predict_results(input in_item_t it);
    logic [PTR_W-1:0]     start_slot;
    logic [PTR_W-1:0]     stop_slot;
    logic [PTR_W-1:0]     slot;
    logic [DATA_BITS-1:0] word;
    logic                 ok;
    int unsigned          span;
    int unsigned          offset;
    start_slot = PTR_W'(int'(it.index) % DEPTH);
    stop_slot  = PTR_W'(int'(it.end_index) % DEPTH);
    case (it.op)
      OP_PUSH: begin
        ok = (fill_q < DEPTH);
        if (ok) begin
          tail_slot_q = PTR_W'((int'(tail_slot_q) + 1) % DEPTH);
          ring_mem[tail_slot_q] = it.push_data[DATA_BITS-1:0];
          fill_q++;
        end
        expected_results.push_back(status_item(ok, '0, 1'b0, '0, fill_q, 1'b1));
      end
      OP_POP: begin
        if (fill_q == 0) begin
          expected_results.push_back(status_item(1'b0, '0, 1'b0, '0, fill_q, 1'b1));
        end else begin
          word = ring_mem[head_slot_q];
          head_slot_q = PTR_W'((int'(head_slot_q) + 1) % DEPTH);
          fill_q--;
          expected_results.push_back(status_item(1'b1, WORD_W'(word), 1'b1, '0, fill_q, 1'b1));
        end
      end
      OP_TRAV_START: begin
        expected_results.push_back(status_item(1'b0, '0, 1'b0, IDX_W'(head_slot_q), fill_q,
                                               1'b1));
      end
      OP_TRAV_AT: begin
        // Valid only inside the occupied window measured from the head
        offset = (int'(start_slot) + DEPTH - int'(head_slot_q)) % DEPTH;
        if (fill_q > 0 && offset < fill_q) begin
          expected_results.push_back(status_item(1'b1, WORD_W'(ring_mem[start_slot]), 1'b1,
                                                 IDX_W'((int'(start_slot) + 1) % DEPTH),
                                                 fill_q, 1'b1));
        end else begin
          expected_results.push_back(status_item(1'b0, '0, 1'b0,
                                                 IDX_W'((int'(head_slot_q) + 1) % DEPTH),
                                                 fill_q, 1'b1));
        end
      end
      OP_RANGE: begin
        // Stream every slot from start to stop, wrapping, occupied or not
        if (start_slot <= stop_slot) begin
          span = int'(stop_slot) - int'(start_slot) + 1;
        end else begin
          span = int'(stop_slot) + DEPTH + 1 - int'(start_slot);
        end
        for (int k = 0; k < span; k++) begin
          slot = PTR_W'((int'(start_slot) + k) % DEPTH);
          expected_results.push_back(status_item(1'b0, WORD_W'(ring_mem[slot]), 1'b1, '0, span,
                                                 (k + 1 == span)));
        end
      end
      default: begin
        expected_results.push_back(status_item(1'b0, '0, 1'b0, '0, fill_q, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want) begin
      report($sformatf("result %0d field %s: got %0h, expected %0h",
                       results_checked, name, got, want));
    end
  endtask

  // Match one result against the oldest prediction
  task automatic compare_result(input out_item_t got);
    out_item_t want;
    results_checked++;
    if (expected_results.size() == 0) begin
      report($sformatf("result %0d arrived with nothing outstanding: %h", results_checked, got));
      return;
    end
    want = expected_results.pop_front();
    check_field("ok",         WORD_W'(got.ok),         WORD_W'(want.ok));
    check_field("data",       got.data,                want.data);
    check_field("has_data",   WORD_W'(got.has_data),   WORD_W'(want.has_data));
    check_field("next_index", WORD_W'(got.next_index), WORD_W'(want.next_index));
    check_field("length",     WORD_W'(got.length),     WORD_W'(want.length));
    check_field("head_slot",  WORD_W'(got.head_slot),  WORD_W'(want.head_slot));
    check_field("tail_slot",  WORD_W'(got.tail_slot),  WORD_W'(want.tail_slot));
    check_field("is_empty",   WORD_W'(got.is_empty),   WORD_W'(want.is_empty));
    check_field("is_full",    WORD_W'(got.is_full),    WORD_W'(want.is_full));
    check_field("last",       WORD_W'(got.last),       WORD_W'(want.last));
  endtask

  // Sample both handshakes on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DEPTH; s++) begin
        ring_mem[s] = '0;
      end
      head_slot_q = '0;
      tail_slot_q = PTR_W'(DEPTH - 1);
      fill_q      = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        compare_result(out_data);
      end
      if (in_valid && !in_stall) begin
        predict_results(in_data);
      end
    end
    pending_results = expected_results.size();
  end

endmodule

[bench/ring_fifo_with_indexed_read_core_tb.sv]
// ---------------------------------------------------------------------------
// ring_fifo_with_indexed_read_core_tb
// Drives push, pop, traverse and range-read transactions into the ring FIFO
// in random bursts against a randomly stalling receiver, including a long
// output hold-off, and reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module ring_fifo_with_indexed_read_core_tb import ffr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RESET_CYCLES = 7;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          TAIL_CYCLES  = 20;
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;

  // Op codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      hold_request = 1'b0;

  int fail_count;
  int pending_results;
  int results_checked;
  int burst_left = 1;
  int op_tally [8];

  ring_fifo_with_indexed_read_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ring_fifo_with_indexed_read_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop on a hang
  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  // Receiver: stall on a changing pattern, or hold off for a long stretch on request
  initial begin : receiver
    stall_mode_t mode;
    int unsigned cyc;
    mode = STALL_NONE;
    cyc  = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        out_stall    <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (cyc % 48 == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
        end
        cyc++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  function automatic in_item_t make_item(input logic [OP_W-1:0] op,
                                         input logic [WORD_W-1:0] word,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [IDX_W-1:0] stop);
    in_item_t it;
    it.op        = op;
    it.push_data = word;
    it.index     = idx;
    it.end_index = stop;
    return it;
  endfunction

  // Random transaction weighted by the current mix; range reads are mostly short
  function automatic in_item_t random_item(input mix_t mix);
    in_item_t    it;
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned span;
    it = make_item(OP_PUSH, $urandom(), IDX_W'($urandom()), IDX_W'($urandom()));
    push_pct = (mix == MIX_FILL) ? 55 : (mix == MIX_DRAIN) ? 10 : 30;
    pop_pct  = (mix == MIX_FILL) ? 10 : (mix == MIX_DRAIN) ? 55 : 30;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      it.op = OP_PUSH;
    end else if (roll < push_pct + pop_pct) begin
      it.op = OP_POP;
    end else if (roll < push_pct + pop_pct + 6) begin
      it.op = OP_TRAV_START;
    end else if (roll < push_pct + pop_pct + 22) begin
      it.op = OP_TRAV_AT;
    end else if (roll < 97) begin
      it.op = OP_RANGE;
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        span = $urandom_range(1, 8);
      end else if (roll < 97) begin
        span = $urandom_range(9, 32);
      end else begin
        span = DEPTH;
      end
      it.end_index = it.index + IDX_W'(span - 1);
    end else begin
      it.op = OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    end
    return it;
  endfunction

  // Offer one transaction, hold it until taken, then pace the next burst
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    op_tally[it.op]++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Pause the sender until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : stimulus
    mix_t mix;
    for (int k = 0; k < 8; k++) begin
      op_tally[k] = 0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty FIFO: failing pop, traverse outside window, full-ring read of cleared slots
    send_item(make_item(OP_POP,        32'h0, 6'd0,  6'd0));
    send_item(make_item(OP_TRAV_START, 32'h0, 6'd0,  6'd0));
    send_item(make_item(OP_TRAV_AT,    32'h0, 6'd0,  6'd0));
    send_item(make_item(OP_RANGE,      32'h0, 6'd0,  6'd63));

    // A few entries with extreme values, then walk and read them
    send_item(make_item(OP_PUSH,       32'h0000_0000, 6'd0, 6'd0));
    send_item(make_item(OP_PUSH,       32'hFFFF_FFFF, 6'd0, 6'd0));
    send_item(make_item(OP_PUSH,       32'hA5A5_A5A5, 6'd0, 6'd0));
    send_item(make_item(OP_PUSH,       32'h5A5A_5A5A, 6'd0, 6'd0));
    send_item(make_item(OP_TRAV_START, 32'h0, 6'd0,  6'd0));
    send_item(make_item(OP_TRAV_AT,    32'h0, 6'd0,  6'd0));
    send_item(make_item(OP_TRAV_AT,    32'h0, 6'd3,  6'd0));
    send_item(make_item(OP_TRAV_AT,    32'h0, 6'd4,  6'd0));
    send_item(make_item(OP_TRAV_AT,    32'h0, 6'd63, 6'd0));
    send_item(make_item(OP_RANGE,      32'h0, 6'd62, 6'd1));
    send_item(make_item(OP_RANGE,      32'h0, 6'd5,  6'd5));
    send_item(make_item(OP_RANGE,      32'h0, 6'd1,  6'd0));
    send_item(make_item(OP_POP,        32'h0, 6'd0,  6'd0));
    send_item(make_item(OP_POP,        32'h0, 6'd0,  6'd0));
    send_item(make_item(OP_TRAV_AT,    32'h0, 6'd0,  6'd0));
    send_item(make_item(OP_SPARE_A,    32'h0, 6'd0,  6'd0));
    send_item(make_item(OP_SPARE_B,    32'hFFFF_FFFF, 6'd63, 6'd63));
    send_item(make_item(OP_SPARE_C,    32'h0, 6'd0,  6'd0));
    send_item(make_item(OP_PUSH,       32'h8000_0001, 6'd63, 6'd63));
    wait_drained();

    // Hold the output while pushing past full so the block backs up
    hold_request <= 1'b1;
    repeat (70) begin
      send_item(make_item(OP_PUSH, $urandom(), IDX_W'($urandom()), IDX_W'($urandom())));
    end
    send_item(make_item(OP_TRAV_START, $urandom(), IDX_W'($urandom()), IDX_W'($urandom())));
    repeat (6) begin
      send_item(make_item(OP_TRAV_AT, $urandom(), IDX_W'($urandom()), IDX_W'($urandom())));
    end
    send_item(make_item(OP_RANGE, $urandom(), 6'd10, 6'd17));
    wait_drained();

    // Pop past empty
    repeat (68) begin
      send_item(make_item(OP_POP, $urandom(), IDX_W'($urandom()), IDX_W'($urandom())));
    end
    wait_drained();

    // Random chunks, each filling, draining or evenly mixed as chosen at random
    for (int chunk = 0; chunk < 9; chunk++) begin
      mix = mix_t'($urandom_range(0, 2));
      repeat (30) send_item(random_item(mix));
      if (chunk % 3 == 2) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d push, %0d pop, %0d traverse start, %0d traverse at index, %0d range read",
             op_tally[OP_PUSH], op_tally[OP_POP], op_tally[OP_TRAV_START],
             op_tally[OP_TRAV_AT], op_tally[OP_RANGE]);
    $display("and %0d spare-code transactions; %0d results compared across a %0d-cycle hold-off",
             op_tally[OP_SPARE_A] + op_tally[OP_SPARE_B] + op_tally[OP_SPARE_C],
             results_checked, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/ffr_pkg.sv
src/ffr_ram.sv
src/ffr_seq.sv
src/ring_fifo_with_indexed_read_core.sv
bench/ring_fifo_with_indexed_read_checker.sv
bench/ring_fifo_with_indexed_read_core_tb.sv
